// ----- sv/jac_pkg.sv -----
`timescale 1ns / 1ps

package jac_pkg;

  // Field widths
  localparam int AxisW    = 3;
  localparam int MvW      = 13;
  localparam int GainW    = 16;
  localparam int ValW     = 30;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Shared adder width and sequencing constants
  localparam int AluW     = 32;
  localparam int ProdW    = MvW + GainW;
  localparam int MulSteps = GainW;
  localparam int DivSteps = ProdW;
  localparam int CntW     = $clog2(DivSteps + 1);

  // Default axis count and register reset values
  localparam int NumAxesDefault = 8;

  localparam logic [MvW-1:0]   MidpointReset = MvW'(1650);
  localparam logic [MvW-1:0]   DeadzoneReset = MvW'(10);
  localparam logic [MvW-1:0]   LimitReset    = MvW'(1600);
  localparam logic [GainW-1:0] GainMulReset  = GainW'(1);
  localparam logic [GainW-1:0] GainDivReset  = GainW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgMidpoint   = 3'd0,
    CfgDeadzone   = 3'd1,
    CfgLimit      = 3'd2,
    CfgGainMul    = 3'd3,
    CfgGainDiv    = 3'd4,
    CfgInvert     = 3'd5,
    CfgChangeOnly = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StOfs,
    StAbs,
    StDz,
    StLim,
    StMul,
    StDiv,
    StNeg,
    StCmp
  } state_e;

  typedef struct packed {
    logic [MvW-1:0]   midpoint;
    logic [MvW-1:0]   deadzone;
    logic [MvW-1:0]   limit;
    logic [GainW-1:0] gain_mul;
    logic [GainW-1:0] gain_div;
    logic             invert;
    logic             change_only;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [AxisW-1:0] rd_axis;
    logic             wr_en;
    logic [AxisW-1:0] wr_axis;
    logic [ValW-1:0]  wr_data;
  } store_req_t;

endpackage

// ----- sv/jac_alu.sv -----
`timescale 1ns / 1ps

module jac_alu (
  input  logic [jac_pkg::AluW-1:0] a_i,
  input  logic [jac_pkg::AluW-1:0] b_i,
  input  logic                     sub_i,
  output logic [jac_pkg::AluW-1:0] sum_o
);

  logic [jac_pkg::AluW-1:0] b_eff;

  // Add, or subtract through the inverted operand and carry in
  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + jac_pkg::AluW'(sub_i);

endmodule

// ----- sv/jac_store.sv -----
`timescale 1ns / 1ps

module jac_store #(
  parameter int AXIS_COUNT = jac_pkg::NumAxesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  jac_pkg::store_req_t      req_i,
  output logic [jac_pkg::ValW-1:0] prev_o
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  logic [jac_pkg::ValW-1:0] mem [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]    valid_q;
  logic [jac_pkg::ValW-1:0] rd_data_q;
  logic                     rd_valid_q;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;

  assign rd_addr = AW'(req_i.rd_axis);
  assign wr_addr = AW'(req_i.wr_axis);

  // Write and read the value memory
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  assign prev_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- sv/jac_core.sv -----
`timescale 1ns / 1ps

module jac_core #(
  parameter int AXIS_COUNT = jac_pkg::NumAxesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jac_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jac_pkg::AxisW-1:0] in_axis_i,
  input  logic [jac_pkg::MvW-1:0]   in_sample_i,
  input  logic                      out_free_i,
  output logic                      push_o,
  output logic [jac_pkg::AxisW-1:0] res_axis_o,
  output logic [jac_pkg::ValW-1:0]  res_value_o,
  output jac_pkg::store_req_t       store_req_o,
  input  logic [jac_pkg::ValW-1:0]  prev_i
);

  localparam int AluW  = jac_pkg::AluW;
  localparam int ProdW = jac_pkg::ProdW;
  localparam int GainW = jac_pkg::GainW;
  localparam int CntW  = jac_pkg::CntW;

  jac_pkg::state_e state_q, state_d;

  logic [AluW-1:0]           acc_q, acc_d;
  logic [jac_pkg::MvW-1:0]   mag_q, mag_d;
  logic [GainW-1:0]          rem_q, rem_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic [jac_pkg::AxisW-1:0] axis_q, axis_d;

  logic [AluW-1:0] alu_a;
  logic [AluW-1:0] alu_b;
  logic            alu_sub;
  logic [AluW-1:0] alu_sum;

  logic [GainW:0]   rem_shift;
  logic [GainW-1:0] divisor;
  logic             axis_ok;
  logic             dz_hit;
  logic             same_val;
  logic             suppress;
  logic             mul_last;
  logic             div_last;

  jac_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign axis_ok   = int'(in_axis_i) < AXIS_COUNT;
  assign divisor   = (cfg_i.gain_div == '0) ? GainW'(1) : cfg_i.gain_div;
  assign rem_shift = {rem_q, acc_q[ProdW-1]};
  assign dz_hit    = alu_sum[AluW-1] || (alu_sum == '0);
  assign same_val  = alu_sum[jac_pkg::ValW-1:0] == '0;
  assign suppress  = cfg_i.change_only && same_val;
  assign mul_last  = cnt_q == CntW'(jac_pkg::MulSteps - 1);
  assign div_last  = cnt_q == CntW'(jac_pkg::DivSteps - 1);

  // Sequence the steps of one sample
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jac_pkg::StIdle: begin
        if (in_valid_i && axis_ok) begin
          state_d = jac_pkg::StOfs;
        end
      end
      jac_pkg::StOfs: state_d = jac_pkg::StAbs;
      jac_pkg::StAbs: state_d = jac_pkg::StDz;
      jac_pkg::StDz:  state_d = dz_hit ? jac_pkg::StNeg : jac_pkg::StLim;
      jac_pkg::StLim: state_d = jac_pkg::StMul;
      jac_pkg::StMul: begin
        if (mul_last) begin
          state_d = jac_pkg::StDiv;
        end
      end
      jac_pkg::StDiv: begin
        if (div_last) begin
          state_d = jac_pkg::StNeg;
        end
      end
      jac_pkg::StNeg: state_d = jac_pkg::StCmp;
      jac_pkg::StCmp: begin
        if (suppress || out_free_i) begin
          state_d = jac_pkg::StIdle;
        end
      end
      default: state_d = jac_pkg::StIdle;
    endcase
  end

  // Drive the shared adder and the working registers
  always_comb begin
    acc_d   = acc_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    axis_d  = axis_q;
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      jac_pkg::StIdle: begin
        acc_d  = AluW'(in_sample_i);
        axis_d = in_axis_i;
      end
      jac_pkg::StOfs: begin
        // Offset from the centre, sign kept aside
        alu_b   = AluW'(cfg_i.midpoint);
        alu_sub = 1'b1;
        acc_d   = alu_sum;
        neg_d   = alu_sum[AluW-1];
      end
      jac_pkg::StAbs: begin
        alu_a   = '0;
        alu_b   = acc_q;
        alu_sub = 1'b1;
        if (neg_q) begin
          acc_d = alu_sum;
        end
      end
      jac_pkg::StDz: begin
        // Drop offsets inside the deadzone, shrink the rest
        alu_b   = AluW'(cfg_i.deadzone);
        alu_sub = 1'b1;
        acc_d   = dz_hit ? '0 : alu_sum;
      end
      jac_pkg::StLim: begin
        alu_a   = AluW'(cfg_i.limit);
        alu_b   = acc_q;
        alu_sub = 1'b1;
        mag_d   = alu_sum[AluW-1] ? cfg_i.limit : acc_q[jac_pkg::MvW-1:0];
        acc_d   = '0;
        rem_d   = cfg_i.gain_mul;
        cnt_d   = '0;
      end
      jac_pkg::StMul: begin
        // Shift and add, multiplier bits from the top
        alu_a = {acc_q[AluW-2:0], 1'b0};
        alu_b = rem_q[GainW-1] ? AluW'(mag_q) : '0;
        acc_d = alu_sum;
        rem_d = {rem_q[GainW-2:0], 1'b0};
        cnt_d = mul_last ? '0 : cnt_q + CntW'(1);
      end
      jac_pkg::StDiv: begin
        // Restoring division, quotient shifts in below the dividend
        alu_a   = AluW'(rem_shift);
        alu_b   = AluW'(divisor);
        alu_sub = 1'b1;
        if (!alu_sum[AluW-1]) begin
          rem_d = alu_sum[GainW-1:0];
        end else begin
          rem_d = rem_shift[GainW-1:0];
        end
        acc_d = AluW'({acc_q[ProdW-2:0], !alu_sum[AluW-1]});
        cnt_d = div_last ? '0 : cnt_q + CntW'(1);
      end
      jac_pkg::StNeg: begin
        alu_a   = '0;
        alu_b   = acc_q;
        alu_sub = 1'b1;
        if (neg_q ^ cfg_i.invert) begin
          acc_d = alu_sum;
        end
      end
      jac_pkg::StCmp: begin
        alu_a   = AluW'(acc_q[jac_pkg::ValW-1:0]);
        alu_b   = AluW'(prev_i);
        alu_sub = 1'b1;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // Handshake, store requests and result
  always_comb begin
    in_ready_o          = state_q == jac_pkg::StIdle;
    store_req_o.rd_en   = in_ready_o && in_valid_i && axis_ok;
    store_req_o.rd_axis = in_axis_i;
    push_o              = (state_q == jac_pkg::StCmp) && !suppress && out_free_i;
    store_req_o.wr_en   = push_o;
    store_req_o.wr_axis = axis_q;
    store_req_o.wr_data = acc_q[jac_pkg::ValW-1:0];
    res_axis_o          = axis_q;
    res_value_o         = acc_q[jac_pkg::ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jac_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    axis_q <= axis_d;
  end

endmodule

// ----- sv/joystick_axis_conditioner_top.sv -----
`timescale 1ns / 1ps
// Each sample takes offset, absolute value, deadzone, limit, 16 multiply steps, 29 divide
// steps, sign and compare on the one shared 32-bit adder; the deadzone path skips limit,
// multiply and divide. A new sample is taken only when idle; out-of-range axes are
// dropped. Reset: registers take their defaults; last values read as zero until written,
// tracked by valid bits, so no clearing pass is needed.

module joystick_axis_conditioner_top #(
  parameter int AXIS_COUNT = jac_pkg::NumAxesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Sample stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [15:0]                  s_axis_tdata_i,   // [12:0] sample_mv
  input  logic [jac_pkg::AxisW-1:0]    s_axis_tuser_i,   // [2:0] axis_index
  // Result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,   // [29:0] axis_value
  output logic [jac_pkg::AxisW-1:0]    m_axis_tuser_o,   // [2:0] axis_id
  // Register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jac_pkg::CfgDataW-1:0] cfg_data_i
);

  jac_pkg::cfg_t cfg_q;

  logic                      out_valid_q;
  logic [jac_pkg::AxisW-1:0] out_axis_q;
  logic [jac_pkg::ValW-1:0]  out_value_q;

  logic                      out_free;
  logic                      core_push;
  logic [jac_pkg::AxisW-1:0] core_axis;
  logic [jac_pkg::ValW-1:0]  core_value;
  logic [jac_pkg::ValW-1:0]  prev_value;
  jac_pkg::store_req_t       store_req;

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.midpoint    <= jac_pkg::MidpointReset;
      cfg_q.deadzone    <= jac_pkg::DeadzoneReset;
      cfg_q.limit       <= jac_pkg::LimitReset;
      cfg_q.gain_mul    <= jac_pkg::GainMulReset;
      cfg_q.gain_div    <= jac_pkg::GainDivReset;
      cfg_q.invert      <= 1'b0;
      cfg_q.change_only <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (jac_pkg::cfg_idx_e'(cfg_index_i))
        jac_pkg::CfgMidpoint:   cfg_q.midpoint    <= cfg_data_i[jac_pkg::MvW-1:0];
        jac_pkg::CfgDeadzone:   cfg_q.deadzone    <= cfg_data_i[jac_pkg::MvW-1:0];
        jac_pkg::CfgLimit:      cfg_q.limit       <= cfg_data_i[jac_pkg::MvW-1:0];
        jac_pkg::CfgGainMul:    cfg_q.gain_mul    <= cfg_data_i[jac_pkg::GainW-1:0];
        jac_pkg::CfgGainDiv:    cfg_q.gain_div    <= cfg_data_i[jac_pkg::GainW-1:0];
        jac_pkg::CfgInvert:     cfg_q.invert      <= cfg_data_i[0];
        jac_pkg::CfgChangeOnly: cfg_q.change_only <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  jac_core #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_axis_i   (s_axis_tuser_i),
    .in_sample_i (s_axis_tdata_i[jac_pkg::MvW-1:0]),
    .out_free_i  (out_free),
    .push_o      (core_push),
    .res_axis_o  (core_axis),
    .res_value_o (core_value),
    .store_req_o (store_req),
    .prev_i      (prev_value)
  );

  jac_store #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .prev_o (prev_value)
  );

  // Hold the result until the sink takes it
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_push) begin
      out_axis_q  <= core_axis;
      out_value_q <= core_value;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_axis_q;
  assign m_axis_tdata_o  = {2'b00, out_value_q};

  // A result never overwrites one still waiting
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_push |-> (!out_valid_q || m_axis_tready_i))
    else $error("result pushed into a full output register");

  // A sample for a missing axis is dropped without starting work
  a_drop_bad_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && int'(s_axis_tuser_i) >= AXIS_COUNT)
      |=> s_axis_tready_o)
    else $error("out-of-range axis started processing");

  // A valid sample keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && int'(s_axis_tuser_i) < AXIS_COUNT)
      |=> !s_axis_tready_o)
    else $error("ready while a sample is in progress");

  // Only existing axes are reported
  a_out_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> int'(m_axis_tuser_o) < AXIS_COUNT)
    else $error("result for an axis beyond the axis count");

endmodule
